@@ rtl/sdlp_pkg.sv @@
// Shared types and constants for the switch debounce and long-press core.
// Holds the sample and event transaction structs, event codes and register
// indexes. No dependencies.
package sdlp_pkg;

  localparam int TICK_BITS_DEFAULT = 32;

  localparam logic [15:0] DEF_SAMPLE_INTERVAL = 16'd10;
  localparam logic [2:0]  DEF_STABLE_SAMPLES  = 3'd3;
  localparam logic [23:0] DEF_LONG_PRESS      = 24'd50000;
  localparam logic [23:0] DEF_CALL_HOLDOFF    = 24'd22000;
  localparam logic        DEF_START_MODE      = 1'b1;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SAMPLE_INTERVAL = 3'd0,
    REG_STABLE_SAMPLES  = 3'd1,
    REG_LONG_PRESS      = 3'd2,
    REG_CALL_HOLDOFF    = 3'd3,
    REG_START_MODE      = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    EVT_PRESS  = 2'd0,
    EVT_CALL   = 2'd1,
    EVT_TOGGLE = 2'd2
  } evt_kind_t;

  typedef struct packed {
    logic [31:0] now_tick;
    logic        switch_level;
  } smp_t;

  typedef struct packed {
    evt_kind_t   event_kind;
    logic [31:0] press_start;
    logic [28:0] span_ms;
    logic        mode_now;
  } evt_t;

endpackage

@@ rtl/switch_debounce_long_press_core.sv @@
// Switch debounce core with long-press protocol mode toggle.
// Depends on sdlp_pkg for transaction structs, event codes and register
// indexes.
//
// Usage: each sample transaction (smp_valid/smp_stall/smp_data) carries
// the free-running tick count and the raw active-low switch pin. The core
// samples the pin once the sample interval has passed, debounces it and
// emits at most one event transaction (evt_valid/evt_stall/evt_data) per
// sample: a press report in new mode, a call in old mode (subject to the
// holdoff), or a mode toggle when a press is held long enough.
// An accepted sample's event passes the decision register, which takes the
// debounce and event decision, and then the output register, which takes the
// divide by ten, done as a halving and a 32 by 32 reciprocal multiply. A new
// sample is accepted every cycle while smp_stall is low. When the receiver
// stalls, the output register holds its event and the decision register
// behind it still takes samples until one of them causes an event; after
// that smp_stall rises until the output moves.
// Configuration writes take effect at the next edge and should only be
// made while no event is in flight. Writing start_mode also loads the
// current mode. Synchronous reset restores all registers to their
// defaults and empties both pipeline registers.
module switch_debounce_long_press_core
  import sdlp_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     smp_valid,
  output logic                     smp_stall,
  input  smp_t                     smp_data,
  output logic                     evt_valid,
  input  logic                     evt_stall,
  output evt_t                     evt_data,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Stored ticks never exceed the 32-bit input, so they need at most NW bits.
  localparam int NW = (TICK_BITS < 32) ? TICK_BITS : 32;
  localparam int CW = (TICK_BITS > 24) ? TICK_BITS : 24;
  localparam int DW = (TICK_BITS > 34) ? TICK_BITS : 34;
  localparam logic [DW-1:0] SAT_LIMIT = DW'(64'd5368709120);
  localparam logic [31:0]   RECIP5    = 32'hCCCC_CCCD;
  localparam logic [28:0]   DUR_MAX   = 29'h1FFF_FFFF;

  typedef struct packed {
    evt_kind_t   kind;
    logic [31:0] press_start;
    logic [31:0] half_diff;
    logic        sat;
    logic        mode;
  } dec_t;

  // Configuration registers.
  logic [15:0] sample_interval;
  logic [2:0]  stable_samples;
  logic [23:0] long_press;
  logic [23:0] call_holdoff;

  // Debounce state.
  logic [NW-1:0] last_sample_at, last_sample_at_next;
  logic          previous_sample, previous_sample_next;
  logic          debounced_level, debounced_level_next;
  logic [2:0]    equal_count, equal_count_next;
  logic [NW-1:0] press_began, press_began_next;
  logic [NW-1:0] last_call_at, last_call_at_next;
  logic          hold_handled, hold_handled_next;
  logic          mode_is_new, mode_is_new_next;

  // Pipeline registers.
  logic a_valid, b_valid;
  dec_t a_reg, a_next;
  evt_t b_reg;

  logic a_go, smp_fire, emit_hit, toggle_hit;
  logic [NW-1:0]        now;
  logic [TICK_BITS-1:0] d_sample, d_call, d_press;
  logic [DW-1:0]        d_press_ext;
  logic                 sample_due, level_taken, call_ok;
  logic [63:0]          prod;

  assign a_go      = !b_valid || !evt_stall;
  assign smp_stall = a_valid && !a_go;
  assign smp_fire  = smp_valid && !smp_stall;

  assign now      = smp_data.now_tick[NW-1:0];
  assign d_sample = TICK_BITS'(now) - TICK_BITS'(last_sample_at);
  assign d_call   = TICK_BITS'(now) - TICK_BITS'(last_call_at);

  always_comb begin
    last_sample_at_next  = last_sample_at;
    previous_sample_next = previous_sample;
    debounced_level_next = debounced_level;
    equal_count_next     = equal_count;
    press_began_next     = press_began;
    last_call_at_next    = last_call_at;
    hold_handled_next    = hold_handled;
    mode_is_new_next     = mode_is_new;
    emit_hit             = 1'b0;
    toggle_hit           = 1'b0;
    level_taken          = 1'b0;
    call_ok              = 1'b0;
    a_next.kind          = EVT_PRESS;
    a_next.mode          = mode_is_new;

    sample_due = CW'(d_sample) >= CW'(sample_interval);

    if (smp_fire && sample_due) begin
      last_sample_at_next = now;
      if (smp_data.switch_level == previous_sample) begin
        if (equal_count < stable_samples) begin
          equal_count_next = equal_count + 3'd1;
        end
      end else begin
        equal_count_next     = 3'd0;
        previous_sample_next = smp_data.switch_level;
      end

      level_taken = (equal_count_next == stable_samples) &&
                    (smp_data.switch_level != debounced_level);
      if (level_taken) begin
        debounced_level_next = smp_data.switch_level;
        if (!smp_data.switch_level) begin
          press_began_next  = now;
          hold_handled_next = 1'b0;
        end else if (!hold_handled) begin
          if (mode_is_new) begin
            emit_hit    = 1'b1;
            a_next.kind = EVT_PRESS;
          end else begin
            // A stored call tick of zero means no call has been made yet.
            call_ok = (last_call_at == '0) || (CW'(d_call) >= CW'(call_holdoff));
            if (call_ok) begin
              emit_hit          = 1'b1;
              a_next.kind       = EVT_CALL;
              last_call_at_next = now;
            end
          end
        end
      end
    end

    // Hold time measured against the start tick after this sample's update.
    d_press = TICK_BITS'(now) - TICK_BITS'(press_began_next);

    if (smp_fire && sample_due && !debounced_level_next && !hold_handled_next &&
        (CW'(d_press) >= CW'(long_press))) begin
      toggle_hit        = 1'b1;
      emit_hit          = 1'b1;
      hold_handled_next = 1'b1;
      mode_is_new_next  = !mode_is_new;
      a_next.kind       = EVT_TOGGLE;
      a_next.mode       = !mode_is_new;
    end

    if (cfg_write && (cfg_index == REG_START_MODE)) begin
      mode_is_new_next = cfg_data[0];
    end

    d_press_ext        = DW'(d_press);
    a_next.press_start = 32'(press_began_next);
    a_next.sat         = d_press_ext >= SAT_LIMIT;
    a_next.half_diff   = d_press_ext[32:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= DEF_SAMPLE_INTERVAL;
      stable_samples  <= DEF_STABLE_SAMPLES;
      long_press      <= DEF_LONG_PRESS;
      call_holdoff    <= DEF_CALL_HOLDOFF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SAMPLE_INTERVAL: sample_interval <= cfg_data[15:0];
        REG_STABLE_SAMPLES:  stable_samples  <= cfg_data[2:0];
        REG_LONG_PRESS:      long_press      <= cfg_data;
        REG_CALL_HOLDOFF:    call_holdoff    <= cfg_data;
        // A start_mode write only loads the current mode, in the state update.
        REG_START_MODE:      ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_at  <= '0;
      previous_sample <= 1'b1;
      debounced_level <= 1'b1;
      equal_count     <= 3'd0;
      press_began     <= '0;
      last_call_at    <= '0;
      hold_handled    <= 1'b0;
      mode_is_new     <= DEF_START_MODE;
    end else begin
      last_sample_at  <= last_sample_at_next;
      previous_sample <= previous_sample_next;
      debounced_level <= debounced_level_next;
      equal_count     <= equal_count_next;
      press_began     <= press_began_next;
      last_call_at    <= last_call_at_next;
      hold_handled    <= hold_handled_next;
      mode_is_new     <= mode_is_new_next;
    end
  end

  // The divide by ten is a halving followed by a reciprocal multiply by five.
  assign prod = 64'(a_reg.half_diff) * 64'(RECIP5);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (!smp_stall) begin
        a_valid <= smp_fire && emit_hit;
      end
      if (!b_valid || !evt_stall) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!smp_stall) begin
      a_reg <= a_next;
    end
    if (!b_valid || !evt_stall) begin
      b_reg.event_kind  <= a_reg.kind;
      b_reg.press_start <= a_reg.press_start;
      b_reg.span_ms     <= a_reg.sat ? DUR_MAX : prod[62:34];
      b_reg.mode_now    <= a_reg.mode;
    end
  end

  assign evt_valid = b_valid;
  assign evt_data  = b_reg;

  // Input is only held off while the decision register is full.
  a_stall_needs_data: assert property (@(posedge clk) disable iff (rst)
    smp_stall |-> a_valid)
    else $error("sample stalled with an empty decision register");

  a_reset_empties: assert property (@(posedge clk)
    !rst && $past(rst) |-> !evt_valid && !a_valid)
    else $error("pipeline not empty after reset");

  a_toggle_reaches_dec: assert property (@(posedge clk) disable iff (rst)
    toggle_hit |=> a_valid && (a_reg.kind == EVT_TOGGLE) && (a_reg.mode == mode_is_new))
    else $error("mode toggle did not reach the decision register");

  a_full_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    a_valid && b_valid && evt_stall |=> a_valid && b_valid && $stable(a_reg))
    else $error("stalled pipeline lost or changed an event");

endmodule

@@ dv/switch_debounce_long_press_core_test.sv @@
// Self-checking testbench for switch_debounce_long_press_core.
// Drives tick-stamped switch samples against a local debounce predictor and
// checks every event transaction; depends on sdlp_pkg and the core itself.
module switch_debounce_long_press_core_test;
  import sdlp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_EVENT,
    ROW_QUIET
  } row_check_t;

  typedef struct packed {
    logic [31:0] tick;
    logic        level;
    row_check_t  check;
    evt_t        want;
  } dir_row_t;

  localparam evt_t NONE = '0;

  // Runs with stable_samples set to 1 and every other register at its reset value.
  localparam dir_row_t DIRECTED [26] = '{
    '{32'd3,          1'b0, ROW_QUIET,   NONE},
    '{32'd10,         1'b0, ROW_PREDICT, NONE},
    '{32'd20,         1'b0, ROW_PREDICT, NONE},
    '{32'd30,         1'b1, ROW_PREDICT, NONE},
    '{32'd40,         1'b1, ROW_EVENT,   '{EVT_PRESS, 32'd20, 29'd2, 1'b1}},
    '{32'd50,         1'b0, ROW_PREDICT, NONE},
    '{32'd60,         1'b0, ROW_PREDICT, NONE},
    '{32'd50060,      1'b0, ROW_EVENT,   '{EVT_TOGGLE, 32'd60, 29'd5000, 1'b0}},
    '{32'd50070,      1'b1, ROW_PREDICT, NONE},
    '{32'd50080,      1'b1, ROW_QUIET,   NONE},
    '{32'd50090,      1'b0, ROW_PREDICT, NONE},
    '{32'd50100,      1'b0, ROW_PREDICT, NONE},
    '{32'd50110,      1'b1, ROW_PREDICT, NONE},
    '{32'd50120,      1'b1, ROW_EVENT,   '{EVT_CALL, 32'd50100, 29'd2, 1'b0}},
    '{32'd50130,      1'b0, ROW_PREDICT, NONE},
    '{32'd50140,      1'b0, ROW_PREDICT, NONE},
    '{32'd50150,      1'b1, ROW_PREDICT, NONE},
    '{32'd50160,      1'b1, ROW_QUIET,   NONE},
    '{32'hFFFF_FFE2,  1'b0, ROW_PREDICT, NONE},
    '{32'hFFFF_FFEC,  1'b0, ROW_PREDICT, NONE},
    '{32'hFFFF_FFF6,  1'b1, ROW_PREDICT, NONE},
    '{32'd0,          1'b1, ROW_EVENT,   '{EVT_CALL, 32'hFFFF_FFEC, 29'd2, 1'b0}},
    '{32'd10,         1'b0, ROW_PREDICT, NONE},
    '{32'd20,         1'b0, ROW_PREDICT, NONE},
    '{32'd30,         1'b1, ROW_PREDICT, NONE},
    '{32'd40,         1'b1, ROW_EVENT,   '{EVT_CALL, 32'd20, 29'd2, 1'b0}}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     smp_valid = 1'b0;
  logic                     smp_stall;
  smp_t                     smp_data = '0;
  logic                     evt_valid;
  logic                     evt_stall = 1'b0;
  evt_t                     evt_data;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor copy of the registers and the debounce state.
  logic [15:0] cfg_interval   = DEF_SAMPLE_INTERVAL;
  logic [2:0]  cfg_stable     = DEF_STABLE_SAMPLES;
  logic [23:0] cfg_long       = DEF_LONG_PRESS;
  logic [23:0] cfg_holdoff    = DEF_CALL_HOLDOFF;
  logic [31:0] last_sample_at = '0;
  logic        prev_sample    = 1'b1;
  logic        deb_level      = 1'b1;
  logic [2:0]  equal_cnt      = '0;
  logic [31:0] press_began    = '0;
  logic [31:0] last_call_at   = '0;
  logic        hold_done      = 1'b0;
  logic        mode_new       = DEF_START_MODE;

  evt_t events_due [$];
  evt_t due_event;
  int   mismatch_count = 0;
  int   events_checked = 0;
  int   items_sent     = 0;
  int   samples_taken  = 0;
  int   cycle_count    = 0;
  int   rx_hold_requests = 0;
  int   rx_hold_served   = 0;
  int   rx_hold_left     = 0;
  bit   calm = 1'b0;

  switch_debounce_long_press_core DUT (
    .clk       (clk),
    .rst       (rst),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp_data  (smp_data),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_data  (evt_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic evt_t build_event(input evt_kind_t kind, input logic [31:0] now);
    evt_t        ev;
    logic [31:0] span;
    span = now - press_began;
    ev.event_kind  = kind;
    ev.press_start = press_began;
    ev.span_ms     = 29'(span / 32'd10);
    ev.mode_now    = mode_new;
    return ev;
  endfunction

  // Advances the debounce state by one sample transaction; returns 1 when it
  // causes an event.
  function automatic bit predict_debounce(input smp_t s, output evt_t ev, output bit taken);
    logic [31:0] now;
    logic [31:0] gap;
    logic        raw;
    bit          fired;
    now   = s.now_tick;
    raw   = s.switch_level;
    ev    = '0;
    taken = 1'b0;
    fired = 1'b0;
    gap   = now - last_sample_at;
    if (gap < {16'd0, cfg_interval}) return 1'b0;
    taken = 1'b1;
    last_sample_at = now;
    if (raw == prev_sample) begin
      if (equal_cnt < cfg_stable) equal_cnt = equal_cnt + 3'd1;
    end else begin
      equal_cnt   = '0;
      prev_sample = raw;
    end
    if (equal_cnt == cfg_stable && raw != deb_level) begin
      deb_level = raw;
      if (!raw) begin
        press_began = now;
        hold_done   = 1'b0;
      end else if (!hold_done) begin
        gap = now - last_call_at;
        if (mode_new) begin
          ev    = build_event(EVT_PRESS, now);
          fired = 1'b1;
        end else if (last_call_at == '0 || gap >= {8'd0, cfg_holdoff}) begin
          ev           = build_event(EVT_CALL, now);
          last_call_at = now;
          fired        = 1'b1;
        end
      end
    end
    gap = now - press_began;
    if (!deb_level && !hold_done && gap >= {8'd0, cfg_long}) begin
      mode_new  = ~mode_new;
      hold_done = 1'b1;
      ev        = build_event(EVT_TOGGLE, now);
      fired     = 1'b1;
    end
    return fired;
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_BITS-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SAMPLE_INTERVAL: cfg_interval = val[15:0];
      REG_STABLE_SAMPLES:  cfg_stable = val[2:0];
      REG_LONG_PRESS:      cfg_long = val[23:0];
      REG_CALL_HOLDOFF:    cfg_holdoff = val[23:0];
      REG_START_MODE:      mode_new = val[0];
      default: ;
    endcase
  endtask

  task automatic program_phase(input logic [15:0] iv, input logic [2:0] st,
                               input logic [23:0] lp, input logic [23:0] ho,
                               input logic md);
    write_reg(REG_SAMPLE_INTERVAL, {8'd0, iv});
    write_reg(REG_STABLE_SAMPLES, {21'd0, st});
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_CALL_HOLDOFF, ho);
    write_reg(REG_START_MODE, {23'd0, md});
    cfg_write <= 1'b0;
  endtask

  // Offers one sample transaction, with an occasional gap first, and returns
  // at the edge that accepts it.
  task automatic offer(input smp_t s);
    if (!calm && $urandom_range(0, 99) < 7) begin
      smp_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    smp_valid <= 1'b1;
    smp_data  <= s;
    @(posedge clk);
    while (smp_stall) @(posedge clk);
    items_sent++;
  endtask

  // The sender stops until every expected event has come and the pipeline
  // has had time to empty.
  task automatic drain();
    smp_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d events outstanding",
               cycle_count, events_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      evt_stall <= 1'b0;
    end else begin
      if (evt_valid && !evt_stall) begin
        events_checked++;
        if (events_due.size() == 0) begin
          log_mismatch($sformatf("unexpected event kind %0d start %h ms %0d mode %0d",
                                 evt_data.event_kind, evt_data.press_start,
                                 evt_data.span_ms, evt_data.mode_now));
        end else begin
          due_event = events_due.pop_front();
          if (evt_data.event_kind !== due_event.event_kind ||
              evt_data.press_start !== due_event.press_start ||
              evt_data.span_ms !== due_event.span_ms ||
              evt_data.mode_now !== due_event.mode_now) begin
            log_mismatch($sformatf(
                "expected kind %0d start %h ms %0d mode %0d, got kind %0d start %h ms %0d mode %0d",
                due_event.event_kind, due_event.press_start, due_event.span_ms,
                due_event.mode_now, evt_data.event_kind, evt_data.press_start,
                evt_data.span_ms, evt_data.mode_now));
          end
        end
      end
      if (rx_hold_served != rx_hold_requests) begin
        rx_hold_served = rx_hold_requests;
        rx_hold_left   = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        evt_stall <= 1'b1;
      end else begin
        evt_stall <= !calm && ($urandom_range(0, 99) < 7);
      end
    end
  end

  initial begin
    dir_row_t    row;
    smp_t        smp;
    evt_t        ev;
    bit          taken;
    bit          fired;
    logic [15:0] iv;
    logic [2:0]  st;
    logic [23:0] lp;
    logic [23:0] ho;
    logic        md;
    logic [31:0] cur_tick;
    logic        run_level;
    int unsigned run_left;
    int unsigned delta;
    int unsigned jump_max;
    int unsigned r;
    int          n;
    int          phase_taken;
    int          phase_fired;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_STABLE_SAMPLES, 24'd1);
    cfg_write <= 1'b0;
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      smp.now_tick     = row.tick;
      smp.switch_level = row.level;
      offer(smp);
      fired = predict_debounce(smp, ev, taken);
      samples_taken += taken;
      case (row.check)
        ROW_PREDICT: if (fired) events_due.push_back(ev);
        ROW_EVENT:   events_due.push_back(row.want);
        default: ;
      endcase
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          iv = DEF_SAMPLE_INTERVAL; st = DEF_STABLE_SAMPLES; lp = DEF_LONG_PRESS;
          ho = DEF_CALL_HOLDOFF; md = DEF_START_MODE;
        end
        1: begin
          iv = 16'd1; st = 3'd7; lp = 24'hFF_FFFF; ho = 24'hFF_FFFF; md = 1'b0;
        end
        // Lowering the stable count below a count already reached.
        2: begin
          iv = 16'hFFFF; st = 3'd1; lp = 24'd0; ho = 24'd0; md = 1'b1;
        end
        3: begin
          iv = 16'd3; st = 3'd0; lp = 24'd200; ho = 24'd500; md = 1'b0;
        end
        default: begin
          iv = $urandom_range(0, 1) ? 16'($urandom_range(1, 40))
                                    : 16'($urandom_range(1, 65535));
          st = 3'($urandom_range(0, 7));
          lp = $urandom_range(0, 1) ? 24'($urandom_range(0, 3000)) : 24'($urandom);
          ho = $urandom_range(0, 1) ? 24'($urandom_range(0, 3000)) : 24'($urandom);
          md = 1'($urandom_range(0, 1));
        end
      endcase
      program_phase(iv, st, lp, ho, md);
      calm        = (ph == 5);
      cur_tick    = $urandom;
      run_level   = 1'b1;
      run_left    = st + 1;
      jump_max    = ((lp > ho) ? lp : ho) * 3 / 2 + iv;
      phase_taken = 0;
      phase_fired = 0;
      n           = 0;
      while ((phase_taken < 125 || phase_fired < 6) && n < 3000) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          delta = $urandom_range(0, iv - 1);
        end else begin
          if (r < 20) delta = $urandom_range(0, jump_max);
          else if (r < 22) delta = $urandom;
          else delta = iv + $urandom_range(0, iv / 2);
          run_left--;
        end
        cur_tick = cur_tick + delta;
        if ($urandom_range(0, 99) < 8) begin
          smp.switch_level = 1'($urandom_range(0, 1));
        end else begin
          smp.switch_level = run_level;
        end
        if (run_left == 0) begin
          run_level = ~run_level;
          run_left  = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(st + 1, st + 4);
        end
        smp.now_tick = cur_tick;
        offer(smp);
        fired = predict_debounce(smp, ev, taken);
        if (fired) events_due.push_back(ev);
        phase_taken   += taken;
        phase_fired   += fired;
        samples_taken += taken;
        // The receiver holds off while the sender keeps going, so the core fills.
        if (n == 40 && (ph == 3 || ph == 6)) rx_hold_requests++;
        n++;
      end
      drain();
    end

    $display("Covered %0d sample transactions (%0d sampled by the debouncer) over %0d settings,",
             items_sent, samples_taken, PHASES + 1);
    $display("with %0d event transactions checked and %0d mismatches.",
             events_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
